>>> rtl/mini_isolation_cone_sums_macros.svh
// Assertion macros used by the checker file of the cone-sum block.
`ifndef MINI_ISOLATION_CONE_SUMS_MACROS_SVH
`define MINI_ISOLATION_CONE_SUMS_MACROS_SVH

// Checked on every clock edge outside reset.
`define MICS_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MICS_CHECK_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mics_pkg.sv
// Types and constants shared by the mini-isolation cone-sum block.
package mics_pkg;

	localparam int ANGLE_FRAC_BITS = 12;

	localparam int PT_W   = 16;
	localparam int ETA_W  = 16;
	localparam int PHI_W  = 15;
	localparam int PDG_W  = 11;
	localparam int VTX_W  = 8;
	localparam int RAD_W  = 13;
	localparam int RSQ_W  = 2 * RAD_W;
	localparam int DEND_W = PT_W + ANGLE_FRAC_BITS;
	localparam int DETA_W = ETA_W + 1;
	localparam int DPHI_W = PHI_W + 2;
	localparam int AE_W   = ETA_W;
	localparam int AP_W   = PHI_W - 1;
	localparam int DR2_W  = 2 * AE_W + 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Pi rounded to the angle precision.
	localparam int PI_INT = (51472 + ((1 << (14 - ANGLE_FRAC_BITS)) >> 1))
		>> (14 - ANGLE_FRAC_BITS);
	localparam logic signed [DPHI_W-1:0] PI_FIX     = DPHI_W'(PI_INT);
	localparam logic signed [DPHI_W-1:0] TWO_PI_FIX = DPHI_W'(2 * PI_INT);

	localparam logic [PDG_W-1:0] PDG_CHARGED_HADRON = 11'd211;
	localparam logic [PDG_W-1:0] PDG_NEUTRAL_HADRON = 11'd130;
	localparam logic [PDG_W-1:0] PDG_PHOTON         = 11'd22;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS    = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KT_SCALE      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PT_THRESHOLD  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGED_DEAD  = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PHOTON_DEAD   = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_DEAD  = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PILEUP_DEAD   = 8'd7;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_CHARGED,
		CLS_PILEUP,
		CLS_NEUTRAL,
		CLS_PHOTON
	} mics_cls_t;

	typedef enum logic [1:0] {
		ST_WAIT,
		ST_DIV,
		ST_CLAMP,
		ST_SQ
	} mics_state_t;

	typedef struct packed {
		logic [RAD_W-1:0] min_radius;
		logic [RAD_W-1:0] max_radius;
		logic [PT_W-1:0]  kt_scale;
		logic [PT_W-1:0]  pt_threshold;
		logic [RAD_W-1:0] charged_dead;
		logic [RAD_W-1:0] photon_dead;
		logic [RAD_W-1:0] neutral_dead;
		logic [RAD_W-1:0] pileup_dead;
	} mics_cfg_t;

	localparam mics_cfg_t CFG_RESET = '{
		min_radius:   13'd205,
		max_radius:   13'd819,
		kt_scale:     16'd40,
		pt_threshold: 16'd2,
		charged_dead: 13'd0,
		photon_dead:  13'd41,
		neutral_dead: 13'd41,
		pileup_dead:  13'd41
	};

	typedef struct packed {
		logic             cand_valid;
		logic             last;
		logic [PT_W-1:0]  lep_pt;
		mics_cls_t        cls;
		logic             above;
		logic [PT_W-1:0]  cand_pt;
	} mics_meta_t;

	typedef struct packed {
		mics_meta_t       meta;
		logic [DR2_W-1:0] dr2;
	} mics_item_t;

	typedef struct packed {
		logic              start;
		logic [DEND_W-1:0] dividend;
		logic [PT_W-1:0]   divisor;
	} mics_div_req_t;

	typedef struct packed {
		logic              done;
		logic [DEND_W-1:0] quotient;
	} mics_div_rsp_t;

endpackage

>>> rtl/mics_front.sv
// Front end: accepts candidates, classifies them and computes the squared distance.
module mics_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cand_valid,
	input  logic                                 last,
	input  logic        [mics_pkg::PT_W-1:0]     lep_pt,
	input  logic signed [mics_pkg::ETA_W-1:0]    lep_eta,
	input  logic signed [mics_pkg::PHI_W-1:0]    lep_phi,
	input  logic        [mics_pkg::PT_W-1:0]     cand_pt,
	input  logic signed [mics_pkg::ETA_W-1:0]    cand_eta,
	input  logic signed [mics_pkg::PHI_W-1:0]    cand_phi,
	input  logic signed [mics_pkg::PDG_W-1:0]    cand_pdg_id,
	input  logic signed [mics_pkg::VTX_W-1:0]    cand_vertex,
	input  logic        [mics_pkg::PT_W-1:0]     pt_threshold,
	input  logic                                 q_full,
	output logic                                 push,
	output mics_pkg::mics_item_t                 push_item
);

	logic adv;

	mics_pkg::mics_meta_t                     meta_in;
	logic        [mics_pkg::PDG_W-1:0]        pdg_u;
	logic        [mics_pkg::PDG_W-1:0]        apdg;
	logic signed [mics_pkg::DPHI_W-1:0]       dphi_raw;
	logic signed [mics_pkg::DPHI_W-1:0]       dphi_wrap;
	logic signed [mics_pkg::DETA_W-1:0]       deta;

	logic                                     v_s1, v_s2, v_s3;
	mics_pkg::mics_meta_t                     meta_s1, meta_s2, meta_s3;
	logic signed [mics_pkg::DETA_W-1:0]       deta_s1;
	logic signed [mics_pkg::PHI_W-1:0]        dphi_s1;
	logic        [mics_pkg::AE_W-1:0]         ae_s2;
	logic        [mics_pkg::AP_W-1:0]         ap_s2;
	logic        [2*mics_pkg::AE_W-1:0]       ae2_s3;
	logic        [2*mics_pkg::AP_W-1:0]       ap2_s3;

	// The three stages move together; they hold only when the last one cannot push.
	assign adv      = !v_s3 || !q_full;
	assign in_ready = adv;
	assign push     = v_s3 && !q_full;

	always_comb begin
		pdg_u = cand_pdg_id;
		apdg  = pdg_u[mics_pkg::PDG_W-1] ? (~pdg_u + 11'd1) : pdg_u;

		meta_in.cand_valid = cand_valid;
		meta_in.last       = last;
		meta_in.lep_pt     = lep_pt;
		meta_in.above      = cand_pt > pt_threshold;
		meta_in.cand_pt    = cand_pt;
		unique case (apdg)
			mics_pkg::PDG_CHARGED_HADRON: begin
				meta_in.cls = (cand_vertex == '0) ? mics_pkg::CLS_CHARGED
					: mics_pkg::CLS_PILEUP;
			end
			mics_pkg::PDG_NEUTRAL_HADRON: meta_in.cls = mics_pkg::CLS_NEUTRAL;
			mics_pkg::PDG_PHOTON:         meta_in.cls = mics_pkg::CLS_PHOTON;
			default:                      meta_in.cls = mics_pkg::CLS_NONE;
		endcase
	end

	// The raw phi difference stays within three half turns, so one correction wraps it.
	always_comb begin
		deta     = mics_pkg::DETA_W'(cand_eta) - mics_pkg::DETA_W'(lep_eta);
		dphi_raw = mics_pkg::DPHI_W'(cand_phi) - mics_pkg::DPHI_W'(lep_phi);
		if (dphi_raw > mics_pkg::PI_FIX) begin
			dphi_wrap = dphi_raw - mics_pkg::TWO_PI_FIX;
		end else if (dphi_raw < -mics_pkg::PI_FIX) begin
			dphi_wrap = dphi_raw + mics_pkg::TWO_PI_FIX;
		end else begin
			dphi_wrap = dphi_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_in;
			deta_s1 <= deta;
			dphi_s1 <= mics_pkg::PHI_W'(dphi_wrap);

			meta_s2 <= meta_s1;
			ae_s2   <= deta_s1[mics_pkg::DETA_W-1] ? mics_pkg::AE_W'(-deta_s1)
				: mics_pkg::AE_W'(deta_s1);
			ap_s2   <= dphi_s1[mics_pkg::PHI_W-1] ? mics_pkg::AP_W'(-dphi_s1)
				: mics_pkg::AP_W'(dphi_s1);

			meta_s3 <= meta_s2;
			ae2_s3  <= ae_s2 * ae_s2;
			ap2_s3  <= ap_s2 * ap_s2;
		end
	end

	assign push_item.meta = meta_s3;
	assign push_item.dr2  = mics_pkg::DR2_W'(ae2_s3) + mics_pkg::DR2_W'(ap2_s3);

endmodule

>>> rtl/mics_fifo.sv
// Short queue between the front end and the accumulating back end.
module mics_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mics_pkg::mics_item_t push_item,
	input  logic                 pop,
	output mics_pkg::mics_item_t head,
	output logic                 empty,
	output logic                 full
);

	mics_pkg::mics_item_t            mem_q [mics_pkg::QUEUE_DEPTH];
	logic [mics_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [mics_pkg::QPTR_W:0]       count_q;

	assign empty = count_q == '0;
	assign full  = count_q == (mics_pkg::QPTR_W + 1)'(mics_pkg::QUEUE_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/mics_div.sv
// Restoring divider that yields one quotient bit per cycle for the cone radius.
module mics_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mics_pkg::mics_div_req_t req,
	output mics_pkg::mics_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(mics_pkg::DEND_W);

	logic                            busy_q;
	logic                            done_q;
	logic [CNT_W-1:0]                count_q;
	logic [mics_pkg::DEND_W-1:0]     quo_q;
	logic [mics_pkg::PT_W-1:0]       rem_q;
	logic [mics_pkg::PT_W-1:0]       divisor_q;
	logic [mics_pkg::PT_W:0]         rem_sh;
	logic [mics_pkg::PT_W+1:0]       diff;

	// A zero divisor never fails the trial subtraction, so the quotient comes out all ones.
	always_comb begin
		rem_sh = {rem_q, quo_q[mics_pkg::DEND_W-1]};
		diff   = {1'b0, rem_sh} - (mics_pkg::PT_W + 2)'(divisor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CNT_W'(mics_pkg::DEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[mics_pkg::PT_W+1]) begin
				rem_q <= diff[mics_pkg::PT_W-1:0];
				quo_q <= {quo_q[mics_pkg::DEND_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[mics_pkg::PT_W-1:0];
				quo_q <= {quo_q[mics_pkg::DEND_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> rtl/mics_back.sv
// Back end: sets the cone per run, accumulates the four sums and holds the result.
module mics_back #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mics_pkg::mics_cfg_t       cfg,
	input  logic                      empty,
	input  mics_pkg::mics_item_t      head,
	output logic                      pop,
	output mics_pkg::mics_div_req_t   div_req,
	input  mics_pkg::mics_div_rsp_t   div_rsp,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [SUM_WIDTH-1:0]      charged_sum,
	output logic [SUM_WIDTH-1:0]      neutral_sum,
	output logic [SUM_WIDTH-1:0]      photon_sum,
	output logic [SUM_WIDTH-1:0]      pileup_sum
);

	function automatic logic [SUM_WIDTH-1:0] sat_add(
		input logic [SUM_WIDTH-1:0]      a,
		input logic [mics_pkg::PT_W-1:0] b
	);
		logic [SUM_WIDTH:0] s;
		s = {1'b0, a} + (SUM_WIDTH + 1)'(b);
		return s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
	endfunction

	mics_pkg::mics_state_t          state_q, state_nxt;
	logic                           in_run_q;
	logic                           out_valid_q;
	logic                           out_free;
	logic [mics_pkg::RAD_W-1:0]     radius_q, clamp_r;
	logic [mics_pkg::RSQ_W-1:0]     cone_sq_q;
	logic [mics_pkg::RSQ_W-1:0]     charged_sq_q, photon_sq_q, neutral_sq_q, pileup_sq_q;
	logic [SUM_WIDTH-1:0]           charged_acc_q, neutral_acc_q, photon_acc_q, pileup_acc_q;
	logic [SUM_WIDTH-1:0]           charged_nxt, neutral_nxt, photon_nxt, pileup_nxt;
	logic [SUM_WIDTH-1:0]           charged_out_q, neutral_out_q, photon_out_q, pileup_out_q;
	logic                           in_cone;
	logic                           add_charged, add_neutral, add_photon, add_pileup;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mics_pkg::ST_WAIT: begin
				if (!empty && !in_run_q) begin
					state_nxt = mics_pkg::ST_DIV;
				end
			end
			mics_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_nxt = mics_pkg::ST_CLAMP;
				end
			end
			mics_pkg::ST_CLAMP: state_nxt = mics_pkg::ST_SQ;
			mics_pkg::ST_SQ:    state_nxt = mics_pkg::ST_WAIT;
			default:            state_nxt = mics_pkg::ST_WAIT;
		endcase
	end

	// An item that opens a run waits at the queue head until its radius is known.
	always_comb begin
		pop              = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = mics_pkg::DEND_W'(cfg.kt_scale) << mics_pkg::ANGLE_FRAC_BITS;
		div_req.divisor  = head.meta.lep_pt;
		unique case (state_q)
			mics_pkg::ST_WAIT: begin
				pop           = !empty && in_run_q && (!head.meta.last || out_free);
				div_req.start = !empty && !in_run_q;
			end
			default: begin
				pop           = 1'b0;
				div_req.start = 1'b0;
			end
		endcase
	end

	// The lower clamp is applied last, so it wins when the limits cross.
	always_comb begin
		if (div_rsp.quotient > mics_pkg::DEND_W'(cfg.max_radius)) begin
			clamp_r = cfg.max_radius;
		end else begin
			clamp_r = div_rsp.quotient[mics_pkg::RAD_W-1:0];
		end
		if (clamp_r < cfg.min_radius) begin
			clamp_r = cfg.min_radius;
		end
	end

	always_comb begin
		in_cone     = head.meta.cand_valid
			&& (head.dr2 <= mics_pkg::DR2_W'(cone_sq_q));
		add_charged = in_cone && (head.meta.cls == mics_pkg::CLS_CHARGED)
			&& (head.dr2 > mics_pkg::DR2_W'(charged_sq_q));
		add_pileup  = in_cone && (head.meta.cls == mics_pkg::CLS_PILEUP)
			&& head.meta.above && (head.dr2 > mics_pkg::DR2_W'(pileup_sq_q));
		add_neutral = in_cone && (head.meta.cls == mics_pkg::CLS_NEUTRAL)
			&& head.meta.above && (head.dr2 > mics_pkg::DR2_W'(neutral_sq_q));
		add_photon  = in_cone && (head.meta.cls == mics_pkg::CLS_PHOTON)
			&& head.meta.above && (head.dr2 > mics_pkg::DR2_W'(photon_sq_q));

		charged_nxt = add_charged ? sat_add(charged_acc_q, head.meta.cand_pt) : charged_acc_q;
		pileup_nxt  = add_pileup  ? sat_add(pileup_acc_q,  head.meta.cand_pt) : pileup_acc_q;
		neutral_nxt = add_neutral ? sat_add(neutral_acc_q, head.meta.cand_pt) : neutral_acc_q;
		photon_nxt  = add_photon  ? sat_add(photon_acc_q,  head.meta.cand_pt) : photon_acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mics_pkg::ST_WAIT;
			in_run_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			cone_sq_q     <= '0;
			charged_acc_q <= '0;
			neutral_acc_q <= '0;
			photon_acc_q  <= '0;
			pileup_acc_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == mics_pkg::ST_SQ) begin
				cone_sq_q <= radius_q * radius_q;
				in_run_q  <= 1'b1;
			end
			if (pop && head.meta.last) begin
				out_valid_q   <= 1'b1;
				in_run_q      <= 1'b0;
				charged_acc_q <= '0;
				neutral_acc_q <= '0;
				photon_acc_q  <= '0;
				pileup_acc_q  <= '0;
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (pop) begin
					charged_acc_q <= charged_nxt;
					neutral_acc_q <= neutral_nxt;
					photon_acc_q  <= photon_nxt;
					pileup_acc_q  <= pileup_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mics_pkg::ST_CLAMP) begin
			radius_q <= clamp_r;
		end
		if (pop && head.meta.last) begin
			charged_out_q <= charged_nxt;
			neutral_out_q <= neutral_nxt;
			photon_out_q  <= photon_nxt;
			pileup_out_q  <= pileup_nxt;
		end
		charged_sq_q <= cfg.charged_dead * cfg.charged_dead;
		photon_sq_q  <= cfg.photon_dead * cfg.photon_dead;
		neutral_sq_q <= cfg.neutral_dead * cfg.neutral_dead;
		pileup_sq_q  <= cfg.pileup_dead * cfg.pileup_dead;
	end

	assign out_valid   = out_valid_q;
	assign charged_sum = charged_out_q;
	assign neutral_sum = neutral_out_q;
	assign photon_sum  = photon_out_q;
	assign pileup_sum  = pileup_out_q;

endmodule

>>> rtl/mini_isolation_cone_sums.sv
// Top level of the mini-isolation cone-sum block with its configuration registers.
//
// Usage: a lepton's candidates arrive as a run of beats on the in channel
// (in_valid/in_ready), each carrying the lepton's pt, eta and phi. The beat
// marked last closes the run and produces one beat on the out channel
// (out_valid/out_ready) with the four saturated pt sums.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle; indexes above seven are ignored.
// The last beat of a run whose cone is already set passes the front stages and
// the queue into the result register. The first beat of a run waits at the
// queue head while the 28-step radius divider, the clamp and the radius square run.
// Throughput: one candidate per cycle in a run without output stalls, plus the back
// end's per-run setup; a four-entry queue lets the front keep accepting meanwhile.
// Reset clears the pipeline, queue, sums and run state and loads the default
// configuration. A stalled receiver holds the result register; the queue then
// fills and in_ready drops once the last front stage also holds an item.
module mini_isolation_cone_sums #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [mics_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mics_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cand_valid,
	input  logic                                 last,
	input  logic        [mics_pkg::PT_W-1:0]     lep_pt,
	input  logic signed [mics_pkg::ETA_W-1:0]    lep_eta,
	input  logic signed [mics_pkg::PHI_W-1:0]    lep_phi,
	input  logic        [mics_pkg::PT_W-1:0]     cand_pt,
	input  logic signed [mics_pkg::ETA_W-1:0]    cand_eta,
	input  logic signed [mics_pkg::PHI_W-1:0]    cand_phi,
	input  logic signed [mics_pkg::PDG_W-1:0]    cand_pdg_id,
	input  logic signed [mics_pkg::VTX_W-1:0]    cand_vertex,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [SUM_WIDTH-1:0]                 charged_sum,
	output logic [SUM_WIDTH-1:0]                 neutral_sum,
	output logic [SUM_WIDTH-1:0]                 photon_sum,
	output logic [SUM_WIDTH-1:0]                 pileup_sum
);

	mics_pkg::mics_cfg_t      cfg_q;
	mics_pkg::mics_item_t     push_item, head;
	mics_pkg::mics_div_req_t  div_req;
	mics_pkg::mics_div_rsp_t  div_rsp;
	logic                     push, pop, q_empty, q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mics_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mics_pkg::REG_MIN_RADIUS:   cfg_q.min_radius   <= cfg_wdata[mics_pkg::RAD_W-1:0];
				mics_pkg::REG_MAX_RADIUS:   cfg_q.max_radius   <= cfg_wdata[mics_pkg::RAD_W-1:0];
				mics_pkg::REG_KT_SCALE:     cfg_q.kt_scale     <= cfg_wdata[mics_pkg::PT_W-1:0];
				mics_pkg::REG_PT_THRESHOLD: cfg_q.pt_threshold <= cfg_wdata[mics_pkg::PT_W-1:0];
				mics_pkg::REG_CHARGED_DEAD: cfg_q.charged_dead <= cfg_wdata[mics_pkg::RAD_W-1:0];
				mics_pkg::REG_PHOTON_DEAD:  cfg_q.photon_dead  <= cfg_wdata[mics_pkg::RAD_W-1:0];
				mics_pkg::REG_NEUTRAL_DEAD: cfg_q.neutral_dead <= cfg_wdata[mics_pkg::RAD_W-1:0];
				mics_pkg::REG_PILEUP_DEAD:  cfg_q.pileup_dead  <= cfg_wdata[mics_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	mics_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cand_valid   (cand_valid),
		.last         (last),
		.lep_pt       (lep_pt),
		.lep_eta      (lep_eta),
		.lep_phi      (lep_phi),
		.cand_pt      (cand_pt),
		.cand_eta     (cand_eta),
		.cand_phi     (cand_phi),
		.cand_pdg_id  (cand_pdg_id),
		.cand_vertex  (cand_vertex),
		.pt_threshold (cfg_q.pt_threshold),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	mics_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	mics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mics_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.empty       (q_empty),
		.head        (head),
		.pop         (pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.charged_sum (charged_sum),
		.neutral_sum (neutral_sum),
		.photon_sum  (photon_sum),
		.pileup_sum  (pileup_sum)
	);

endmodule

>>> rtl/mics_checker.sv
// Port-level checker for the cone-sum block and its bind to the top level.
`include "mini_isolation_cone_sums_macros.svh"

module mics_checker #(
	parameter int SUM_WIDTH = 24
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 last,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [SUM_WIDTH-1:0] charged_sum,
	input logic [SUM_WIDTH-1:0] neutral_sum,
	input logic [SUM_WIDTH-1:0] photon_sum,
	input logic [SUM_WIDTH-1:0] pileup_sum
);

	// Three pipeline stages, four queue entries and the result register.
	localparam logic [3:0] MAX_PENDING = 4'd8;

	logic [3:0] pending_q;
	logic       last_in, res_out;

	assign last_in = in_valid && in_ready && last;
	assign res_out = out_valid && out_ready;

	// Runs closed at the input whose result beat has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !res_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_out && !last_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`MICS_CHECK_RST(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")
	`MICS_CHECK(a_result_hold, out_valid && !out_ready |=> out_valid && $stable(charged_sum) && $stable(neutral_sum) && $stable(photon_sum) && $stable(pileup_sum), "stalled result changed")
	`MICS_CHECK(a_no_extra_result, out_valid |-> pending_q != 4'd0, "result without a closed run")
	`MICS_CHECK(a_pending_bound, pending_q <= MAX_PENDING, "more closed runs in flight than storage")

endmodule

bind mini_isolation_cone_sums mics_checker #(.SUM_WIDTH(SUM_WIDTH)) u_mics_checker (.*);

>>> verif/mini_isolation_cone_sums_tb.sv
// Self-checking testbench for the mini-isolation cone-sum block with a scoreboard class.
module mini_isolation_cone_sums_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mics_pkg::*;

	localparam int SUMW        = 24;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HALF_TURN   = 12868;
	localparam int CHG         = int'(PDG_CHARGED_HADRON);
	localparam int NEU         = int'(PDG_NEUTRAL_HADRON);
	localparam int PHO         = int'(PDG_PHOTON);
	localparam int CODE_MIN    = -(1 << (PDG_W - 1));
	localparam int CODE_MAX    = (1 << (PDG_W - 1)) - 1;
	localparam int SAT_BEATS   = 4 * 258;

	typedef longint unsigned u64_t;
	typedef logic [CFG_DATA_W-1:0] reg_set_t [8];

	typedef struct {
		logic                    cand_valid;
		logic                    last;
		logic        [PT_W-1:0]  lep_pt;
		logic signed [ETA_W-1:0] lep_eta;
		logic signed [PHI_W-1:0] lep_phi;
		logic        [PT_W-1:0]  cand_pt;
		logic signed [ETA_W-1:0] cand_eta;
		logic signed [PHI_W-1:0] cand_phi;
		logic signed [PDG_W-1:0] cand_pdg_id;
		logic signed [VTX_W-1:0] cand_vertex;
	} cand_beat_t;

	typedef struct {
		logic [SUMW-1:0] charged;
		logic [SUMW-1:0] neutral;
		logic [SUMW-1:0] photon;
		logic [SUMW-1:0] pileup;
	} cone_sums_t;

	class cone_sum_board;
		logic [RAD_W-1:0] min_radius, max_radius;
		logic [RAD_W-1:0] charged_dead, photon_dead, neutral_dead, pileup_dead;
		logic [PT_W-1:0]  kt_scale, pt_threshold;
		bit               in_run;
		u64_t             radius_sq;
		u64_t             charged_acc, neutral_acc, photon_acc, pileup_acc;
		cone_sums_t       pending_sums[$];
		int               fault_count;

		function new();
			min_radius   = CFG_RESET.min_radius;
			max_radius   = CFG_RESET.max_radius;
			kt_scale     = CFG_RESET.kt_scale;
			pt_threshold = CFG_RESET.pt_threshold;
			charged_dead = CFG_RESET.charged_dead;
			photon_dead  = CFG_RESET.photon_dead;
			neutral_dead = CFG_RESET.neutral_dead;
			pileup_dead  = CFG_RESET.pileup_dead;
			in_run = 1'b0;
			radius_sq = 0;
			charged_acc = 0;
			neutral_acc = 0;
			photon_acc = 0;
			pileup_acc = 0;
			fault_count = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_MIN_RADIUS:   min_radius   = data[RAD_W-1:0];
			REG_MAX_RADIUS:   max_radius   = data[RAD_W-1:0];
			REG_KT_SCALE:     kt_scale     = data[PT_W-1:0];
			REG_PT_THRESHOLD: pt_threshold = data[PT_W-1:0];
			REG_CHARGED_DEAD: charged_dead = data[RAD_W-1:0];
			REG_PHOTON_DEAD:  photon_dead  = data[RAD_W-1:0];
			REG_NEUTRAL_DEAD: neutral_dead = data[RAD_W-1:0];
			REG_PILEUP_DEAD:  pileup_dead  = data[RAD_W-1:0];
			default: ;
			endcase
		endfunction

		function u64_t square(u64_t v);
			return v * v;
		endfunction

		function u64_t sat_add(u64_t acc, logic [PT_W-1:0] pt);
			u64_t s;
			s = acc + u64_t'(pt);
			return (s > ((u64_t'(1) << SUMW) - 1)) ? ((u64_t'(1) << SUMW) - 1) : s;
		endfunction

		function void absorb_beat(cand_beat_t b);
			u64_t radius, dr2;
			int   deta, dphi, apdg;
			bit   above;
			// The cone is fixed by the lepton on the opening beat of a run.
			if (!in_run) begin
				if (b.lep_pt == 0)
					radius = u64_t'(max_radius);
				else
					radius = (u64_t'(kt_scale) << ANGLE_FRAC_BITS) / u64_t'(b.lep_pt);
				if (radius > u64_t'(max_radius))
					radius = u64_t'(max_radius);
				if (radius < u64_t'(min_radius))
					radius = u64_t'(min_radius);
				radius_sq = square(radius);
				in_run = 1'b1;
			end
			if (b.cand_valid) begin
				deta = int'(b.cand_eta) - int'(b.lep_eta);
				dphi = int'(b.cand_phi) - int'(b.lep_phi);
				while (dphi > HALF_TURN)
					dphi -= 2 * HALF_TURN;
				while (dphi < -HALF_TURN)
					dphi += 2 * HALF_TURN;
				if (deta < 0)
					deta = -deta;
				if (dphi < 0)
					dphi = -dphi;
				dr2 = square(u64_t'(deta)) + square(u64_t'(dphi));
				apdg = int'(b.cand_pdg_id);
				if (apdg < 0)
					apdg = -apdg;
				above = (b.cand_pt > pt_threshold);
				if (dr2 <= radius_sq) begin
					if (apdg == CHG) begin
						if (b.cand_vertex == 0) begin
							if (dr2 > square(u64_t'(charged_dead)))
								charged_acc = sat_add(charged_acc, b.cand_pt);
						end else if (above && dr2 > square(u64_t'(pileup_dead))) begin
							pileup_acc = sat_add(pileup_acc, b.cand_pt);
						end
					end else if (apdg == NEU) begin
						if (above && dr2 > square(u64_t'(neutral_dead)))
							neutral_acc = sat_add(neutral_acc, b.cand_pt);
					end else if (apdg == PHO) begin
						if (above && dr2 > square(u64_t'(photon_dead)))
							photon_acc = sat_add(photon_acc, b.cand_pt);
					end
				end
			end
			if (b.last) begin
				pending_sums.push_back('{charged_acc[SUMW-1:0], neutral_acc[SUMW-1:0],
					photon_acc[SUMW-1:0], pileup_acc[SUMW-1:0]});
				charged_acc = 0;
				neutral_acc = 0;
				photon_acc = 0;
				pileup_acc = 0;
				in_run = 1'b0;
			end
		endfunction

		function void note_fault(string msg);
			fault_count++;
			if (fault_count <= 10)
				$display("%s", msg);
		endfunction

		function void match_sums(cone_sums_t got);
			cone_sums_t want;
			if (pending_sums.size() == 0) begin
				note_fault("result beat arrived with no sums pending");
				return;
			end
			want = pending_sums.pop_front();
			if (got.charged !== want.charged)
				note_fault($sformatf("charged_sum: expected %0d, got %0d", want.charged, got.charged));
			if (got.neutral !== want.neutral)
				note_fault($sformatf("neutral_sum: expected %0d, got %0d", want.neutral, got.neutral));
			if (got.photon !== want.photon)
				note_fault($sformatf("photon_sum: expected %0d, got %0d", want.photon, got.photon));
			if (got.pileup !== want.pileup)
				note_fault($sformatf("pileup_sum: expected %0d, got %0d", want.pileup, got.pileup));
		endfunction

		function void close_out();
			if (pending_sums.size() != 0) begin
				fault_count += pending_sums.size();
				$display("%0d expected result beats never arrived", pending_sums.size());
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cand_valid = 1'b0;
	logic                     last = 1'b0;
	logic        [PT_W-1:0]   lep_pt = '0;
	logic signed [ETA_W-1:0]  lep_eta = '0;
	logic signed [PHI_W-1:0]  lep_phi = '0;
	logic        [PT_W-1:0]   cand_pt = '0;
	logic signed [ETA_W-1:0]  cand_eta = '0;
	logic signed [PHI_W-1:0]  cand_phi = '0;
	logic signed [PDG_W-1:0]  cand_pdg_id = '0;
	logic signed [VTX_W-1:0]  cand_vertex = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [SUMW-1:0]          charged_sum, neutral_sum, photon_sum, pileup_sum;

	cone_sum_board board;
	bit            quiet = 1'b0;
	int            cycle_count = 0;

	mini_isolation_cone_sums #(
		.SUM_WIDTH(SUMW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cand_valid(cand_valid),
		.last(last),
		.lep_pt(lep_pt),
		.lep_eta(lep_eta),
		.lep_phi(lep_phi),
		.cand_pt(cand_pt),
		.cand_eta(cand_eta),
		.cand_phi(cand_phi),
		.cand_pdg_id(cand_pdg_id),
		.cand_vertex(cand_vertex),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.charged_sum(charged_sum),
		.neutral_sum(neutral_sum),
		.photon_sum(photon_sum),
		.pileup_sum(pileup_sum)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** mini_isolation_cone_sums: FAILED **");
			$finish;
		end
	end

	// Result side: check every accepted beat, then pick the next ready.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready)
			board.match_sums('{charged_sum, neutral_sum, photon_sum, pileup_sum});
		out_ready <= quiet || ($urandom_range(99) >= 15);
	end

	function automatic cand_beat_t mk(bit v, bit l, int lpt, int leta, int lphi, int cpt,
		int ceta, int cphi, int pdg, int vtx);
		cand_beat_t b;
		b.cand_valid  = v;
		b.last        = l;
		b.lep_pt      = PT_W'(lpt);
		b.lep_eta     = ETA_W'(leta);
		b.lep_phi     = PHI_W'(lphi);
		b.cand_pt     = PT_W'(cpt);
		b.cand_eta    = ETA_W'(ceta);
		b.cand_phi    = PHI_W'(cphi);
		b.cand_pdg_id = PDG_W'(pdg);
		b.cand_vertex = VTX_W'(vtx);
		return b;
	endfunction

	function automatic cand_beat_t make_lepton();
		cand_beat_t b;
		b = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		case ($urandom_range(9))
		0:       b.lep_pt = '0;
		1, 2, 3: b.lep_pt = PT_W'($urandom_range(40, 1));
		4, 5, 6: b.lep_pt = PT_W'($urandom_range(1000, 40));
		7:       b.lep_pt = '1;
		default: b.lep_pt = PT_W'($urandom);
		endcase
		b.lep_eta = ETA_W'($urandom);
		if ($urandom_range(99) < 85)
			b.lep_phi = PHI_W'(int'($urandom_range(2 * HALF_TURN)) - HALF_TURN);
		else
			b.lep_phi = PHI_W'($urandom);
		return b;
	endfunction

	function automatic cand_beat_t make_cand(cand_beat_t lep);
		cand_beat_t b;
		int spread, code;
		b = lep;
		b.cand_valid = ($urandom_range(99) >= 8);
		case ($urandom_range(3))
		0:       spread = 60;
		1:       spread = 600;
		2:       spread = 2000;
		default: spread = 0;
		endcase
		if (spread == 0) begin
			b.cand_eta = ETA_W'($urandom);
			b.cand_phi = PHI_W'($urandom);
		end else begin
			b.cand_eta = ETA_W'(int'(lep.lep_eta) + int'($urandom_range(2 * spread)) - spread);
			b.cand_phi = PHI_W'(int'(lep.lep_phi) + int'($urandom_range(2 * spread)) - spread);
		end
		case ($urandom_range(9))
		3, 4:    code = NEU;
		5, 6:    code = PHO;
		7:       code = int'($urandom_range(CODE_MAX - CODE_MIN)) + CODE_MIN;
		default: code = CHG;
		endcase
		if ($urandom_range(1))
			code = -code;
		b.cand_pdg_id = PDG_W'(code);
		b.cand_vertex = ($urandom_range(99) < 60) ? '0 : VTX_W'($urandom);
		case ($urandom_range(9))
		0, 1, 2, 3: b.cand_pt = PT_W'($urandom_range(8));
		4, 5, 6, 7: b.cand_pt = PT_W'($urandom_range(2000));
		8:          b.cand_pt = PT_W'($urandom);
		default:    b.cand_pt = '1;
		endcase
		return b;
	endfunction

	function automatic reg_set_t random_setup();
		reg_set_t v;
		v[REG_MIN_RADIUS]   = CFG_DATA_W'($urandom_range(600))
			| (CFG_DATA_W'($urandom_range(7)) << RAD_W);
		v[REG_MAX_RADIUS]   = CFG_DATA_W'($urandom_range(3000, 300))
			| (CFG_DATA_W'($urandom_range(7)) << RAD_W);
		v[REG_KT_SCALE]     = CFG_DATA_W'($urandom_range(400));
		v[REG_PT_THRESHOLD] = CFG_DATA_W'($urandom_range(20));
		v[REG_CHARGED_DEAD] = CFG_DATA_W'($urandom_range(200));
		v[REG_PHOTON_DEAD]  = CFG_DATA_W'($urandom_range(200))
			| (CFG_DATA_W'($urandom_range(7)) << RAD_W);
		v[REG_NEUTRAL_DEAD] = CFG_DATA_W'($urandom_range(200));
		v[REG_PILEUP_DEAD]  = CFG_DATA_W'($urandom_range(200));
		return v;
	endfunction

	task automatic send_beat(cand_beat_t b);
		while (!quiet && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cand_valid  <= b.cand_valid;
		last        <= b.last;
		lep_pt      <= b.lep_pt;
		lep_eta     <= b.lep_eta;
		lep_phi     <= b.lep_phi;
		cand_pt     <= b.cand_pt;
		cand_eta    <= b.cand_eta;
		cand_phi    <= b.cand_phi;
		cand_pdg_id <= b.cand_pdg_id;
		cand_vertex <= b.cand_vertex;
		do
			@(posedge clk);
		while (!in_ready);
		board.absorb_beat(b);
	endtask

	// Hold off the sender until every pending result is out, then let the
	// pipeline empty for good measure.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_sums.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic program_regs(reg_set_t vals);
		for (int i = 0; i < $size(vals); i++)
			poke_reg(CFG_IDX_W'(i), vals[i]);
		// An index past the last register must leave everything alone.
		poke_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_PILEUP_DEAD) + 1)),
			CFG_DATA_W'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(int budget);
		cand_beat_t lep, b;
		int sent, len;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < budget) begin
			lep = make_lepton();
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
			for (int k = 0; k < len; k++) begin
				b = make_cand(lep);
				b.last = (k == len - 1);
				send_beat(b);
			end
			sent += len;
			if (!paused && sent >= budget / 2) begin
				settle();
				paused = 1'b1;
			end
		end
	endtask

	// One long run at full pt per class, enough to push every sum into saturation.
	task automatic run_saturation();
		cand_beat_t lep, b;
		lep = mk(0, 0, 0, int'($urandom_range(40000)) - 20000,
			int'($urandom_range(2 * HALF_TURN)) - HALF_TURN, 0, 0, 0, 0, 0);
		for (int k = 0; k < SAT_BEATS; k++) begin
			b = lep;
			b.cand_valid = 1'b1;
			b.last = (k == SAT_BEATS - 1);
			b.cand_pt = '1;
			b.cand_eta = ETA_W'(int'(lep.lep_eta) + int'($urandom_range(3000, 1)));
			b.cand_phi = PHI_W'(int'(lep.lep_phi) + int'($urandom_range(6000)) - 3000);
			b.cand_vertex = '0;
			case (k % 4)
			0: b.cand_pdg_id = PDG_W'(CHG);
			1: begin
				b.cand_pdg_id = PDG_W'(-CHG);
				b.cand_vertex = VTX_W'($urandom_range(127, 1));
			end
			2: b.cand_pdg_id = PDG_W'(NEU);
			default: b.cand_pdg_id = PDG_W'(-PHO);
			endcase
			send_beat(b);
		end
	endtask

	initial begin
		reg_set_t setup;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default setup, lepton pt of zero: the cone opens to the upper clamp.
		send_beat(mk(1, 0, 0, 0, 0, 100, 0, 0, CHG, 0));
		send_beat(mk(1, 0, 0, 0, 0, 65535, 819, 0, -CHG, 0));
		send_beat(mk(1, 0, 0, 0, 0, 777, 820, 0, CHG, 0));
		send_beat(mk(1, 0, 0, 0, 0, 50, -41, 0, -NEU, 3));
		send_beat(mk(1, 0, 0, 0, 0, 2, 42, 0, NEU, 0));
		send_beat(mk(1, 0, 0, 0, 0, 3, 0, -42, NEU, 0));
		send_beat(mk(1, 0, 0, 0, 0, 7, 0, 42, PHO, 0));
		send_beat(mk(1, 0, 0, 0, 0, 9, 0, 41, -PHO, 0));
		send_beat(mk(1, 0, 0, 0, 0, 9, 100, 0, CHG, -1));
		send_beat(mk(1, 0, 0, 0, 0, 2, 100, 0, -CHG, 127));
		send_beat(mk(1, 0, 0, 0, 0, 500, 100, 0, CODE_MIN, 0));
		send_beat(mk(1, 0, 0, 0, 0, 500, -100, 0, CODE_MAX, -128));
		send_beat(mk(0, 1, 0, 0, 0, 65535, 10, 10, CHG, 0));
		// A run made of a single empty beat.
		send_beat(mk(0, 1, 65535, -1, -1, 0, 0, 0, 0, 0));
		// Lepton phi past the range and eta at the lower edge; phi must wrap.
		send_beat(mk(1, 0, 1, -32768, 16383, 1000, -32768, -9500, PHO, 0));
		send_beat(mk(1, 0, 1, -32768, 16383, 4000, 32767, 16383, CHG, 0));
		send_beat(mk(1, 0, 1, -32768, 16383, 300, -32768, -16384, NEU, -128));
		send_beat(mk(1, 1, 1, -32768, 16383, 65535, -32500, 16383, CHG, 0));
		run_random(250);

		settle();
		setup[REG_MIN_RADIUS]   = '0;
		setup[REG_MAX_RADIUS]   = CFG_DATA_W'((1 << RAD_W) - 1);
		setup[REG_KT_SCALE]     = '1;
		setup[REG_PT_THRESHOLD] = '0;
		setup[REG_CHARGED_DEAD] = '0;
		setup[REG_PHOTON_DEAD]  = '0;
		setup[REG_NEUTRAL_DEAD] = '0;
		setup[REG_PILEUP_DEAD]  = '0;
		program_regs(setup);
		run_saturation();
		run_random(150);

		// Lower clamp above the upper one, threshold and dead cones at their top.
		settle();
		setup[REG_MIN_RADIUS]   = '1;
		setup[REG_MAX_RADIUS]   = CFG_DATA_W'(7) << RAD_W;
		setup[REG_KT_SCALE]     = '0;
		setup[REG_PT_THRESHOLD] = '1;
		setup[REG_CHARGED_DEAD] = CFG_DATA_W'((1 << RAD_W) - 1);
		setup[REG_PHOTON_DEAD]  = CFG_DATA_W'((1 << RAD_W) - 1);
		setup[REG_NEUTRAL_DEAD] = CFG_DATA_W'((1 << RAD_W) - 1);
		setup[REG_PILEUP_DEAD]  = CFG_DATA_W'((1 << RAD_W) - 1);
		program_regs(setup);
		run_random(100);

		for (int ph = 0; ph < 3; ph++) begin
			settle();
			program_regs(random_setup());
			quiet = (ph == 1);
			run_random(100);
		end
		quiet = 1'b0;

		settle();
		board.close_out();
		if (board.fault_count == 0)
			$display("** mini_isolation_cone_sums: PASSED **");
		else
			$display("** mini_isolation_cone_sums: FAILED **");
		$finish;
	end

endmodule
